// ===== src/three_wire_rtc_serial_master_assert.svh =====
// ----------------------------------------------------------------------------
// three-wire rtc serial master: assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_ASSERT_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_ASSERT_SVH

`ifndef SYNTH

// check a property, held off while reset is high
`define TWRTC_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("twrtc check failed");

// check a property on every edge, reset included
`define TWRTC_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("twrtc check failed");

`else

`define TWRTC_ASSERT(name, clk, rst, prop)
`define TWRTC_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// ===== src/twrtc_pkg.sv =====
// ----------------------------------------------------------------------------
// twrtc_pkg
// shared types, constants and helpers of the three-wire rtc serial master
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package twrtc_pkg;

   localparam int TRANSFER_BITS = 16;
   localparam int BIT_IDX_W     = $clog2(TRANSFER_BITS) + 1;
   localparam int SHIFT_IDX_W   = $clog2(TRANSFER_BITS);

   localparam logic [7:0] HALF_PERIOD_RESET = 8'd4;
   localparam logic [7:0] SETUP_RESET       = 8'd1;

   // rtc register command bytes
   localparam logic [7:0] CMD_SECONDS = 8'h80;
   localparam logic [7:0] CMD_MINUTES = 8'h82;
   localparam logic [7:0] CMD_HOURS   = 8'h84;
   localparam logic [7:0] CMD_DATE    = 8'h86;
   localparam logic [7:0] CMD_MONTH   = 8'h88;
   localparam logic [7:0] CMD_DAY     = 8'h8A;
   localparam logic [7:0] CMD_YEAR    = 8'h8C;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_SETUP = 2'd1,
      PH_LOW   = 2'd2,
      PH_HIGH  = 2'd3
   } phase_type;

   typedef enum logic [0:0] {
      CSR_HALF_PERIOD = 1'b0,
      CSR_SETUP       = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic          valid;
      csr_index_type index;
      logic [7:0]    data;
   } csr_wr_type;

   typedef struct packed {
      logic       start_req;
      logic       operation;
      logic [7:0] reg_address;
      logic [7:0] write_data;
      logic       io_sample;
   } item_type;

   typedef struct packed {
      logic       serial_clock;
      logic       data_out;
      logic       data_drive_enable;
      logic       chip_enable;
      logic       busy_res;
      logic       read_valid;
      logic [7:0] read_value;
   } result_type;

   // valid bits of each time register
   function automatic logic [7:0] reg_mask(input logic [7:0] cmd);
      logic [7:0] m;
      unique case (cmd)
         CMD_SECONDS: m = 8'h7F;
         CMD_MINUTES: m = 8'h7F;
         CMD_HOURS:   m = 8'h1F;
         CMD_DATE:    m = 8'h3F;
         CMD_MONTH:   m = 8'h1F;
         CMD_DAY:     m = 8'h07;
         CMD_YEAR:    m = 8'hFF;
         default:     m = 8'hFF;
      endcase
      return m;
   endfunction

   // value minus six times the tens nibble, tens from the masked byte
   function automatic logic [7:0] bcd_to_bin(input logic [7:0] cmd, input logic [7:0] raw);
      logic [7:0] m;
      logic [3:0] hi;
      m  = raw & reg_mask(cmd);
      hi = m[7:4];
      return m - {2'b00, hi, 2'b00} - {3'b000, hi, 1'b0};
   endfunction

endpackage

`default_nettype wire

// ===== src/twrtc_in_stage.sv =====
// ----------------------------------------------------------------------------
// twrtc_in_stage
// input register holding one accepted tick word until the engine steps it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twrtc_in_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire twrtc_pkg::item_type req_item,
   input  wire logic               advance,
   output logic                    item_valid,
   output twrtc_pkg::item_type     item
);
   import twrtc_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== src/twrtc_engine.sv =====
// ----------------------------------------------------------------------------
// twrtc_engine
// transfer sequencer: timing registers, phase machine, shifter and bcd decode
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twrtc_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire twrtc_pkg::csr_wr_type csr_wr,
   input  wire logic                  step,
   input  wire twrtc_pkg::item_type   item,
   output twrtc_pkg::result_type      result
);
   import twrtc_pkg::*;

   `include "three_wire_rtc_serial_master_assert.svh"

   logic [7:0] half_period_ff, setup_ff;

   phase_type                  phase_ff, phase_in;
   logic                       active_ff, active_in;
   logic                       reading_ff, reading_in;
   logic [7:0]                 cmd_ff, cmd_in;
   logic [TRANSFER_BITS-1:0]   shift_ff, shift_in;
   logic [7:0]                 rx_ff, rx_in;
   logic [BIT_IDX_W-1:0]       bit_ff, bit_in, bit_inc;
   logic [7:0]                 tick_ff, tick_in;
   logic                       read_part_ff, read_part_in;
   logic                       read_done;

   // timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         setup_ff       <= SETUP_RESET;
      end else if (csr_wr.valid) begin
         unique case (csr_wr.index)
            CSR_HALF_PERIOD: half_period_ff <= csr_wr.data;
            CSR_SETUP:       setup_ff       <= csr_wr.data;
            default:         half_period_ff <= half_period_ff;
         endcase
      end
   end

   // last byte of a read is the sampling part
   assign read_part_ff = reading_ff && (bit_ff[BIT_IDX_W-1] || bit_ff[BIT_IDX_W-2]);
   assign bit_inc      = bit_ff + BIT_IDX_W'(1);

   always_comb begin
      phase_in   = phase_ff;
      active_in  = active_ff;
      reading_in = reading_ff;
      cmd_in     = cmd_ff;
      shift_in   = shift_ff;
      rx_in      = rx_ff;
      bit_in     = bit_ff;
      tick_in    = tick_ff;
      read_done  = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (item.start_req) begin
               active_in  = 1'b1;
               reading_in = item.operation;
               cmd_in     = item.reg_address;
               if (item.operation) begin
                  shift_in = TRANSFER_BITS'(item.reg_address + 8'd1);
               end else begin
                  shift_in = TRANSFER_BITS'({item.write_data, item.reg_address});
               end
               rx_in    = 8'd0;
               bit_in   = '0;
               phase_in = PH_SETUP;
               tick_in  = 8'd1;
            end
         end
         PH_SETUP: begin
            if (tick_ff >= setup_ff) begin
               phase_in = PH_LOW;
               tick_in  = 8'd1;
            end else begin
               tick_in = tick_ff + 8'd1;
            end
         end
         PH_LOW: begin
            if (tick_ff >= half_period_ff) begin
               if (read_part_ff) begin
                  rx_in[bit_ff[2:0]] = rx_ff[bit_ff[2:0]] | item.io_sample;
               end
               phase_in = PH_HIGH;
               tick_in  = 8'd1;
            end else begin
               tick_in = tick_ff + 8'd1;
            end
         end
         PH_HIGH: begin
            if (tick_ff >= half_period_ff) begin
               if (bit_inc >= BIT_IDX_W'(TRANSFER_BITS)) begin
                  read_done  = reading_ff;
                  active_in  = 1'b0;
                  reading_in = 1'b0;
                  bit_in     = '0;
                  phase_in   = PH_IDLE;
                  tick_in    = 8'd0;
               end else begin
                  bit_in   = bit_inc;
                  phase_in = PH_LOW;
                  tick_in  = 8'd1;
               end
            end else begin
               tick_in = tick_ff + 8'd1;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   assign read_part_in = reading_in && (bit_in[BIT_IDX_W-1] || bit_in[BIT_IDX_W-2]);

   // pin levels after this tick
   always_comb begin
      result                   = '0;
      result.serial_clock      = (phase_in == PH_HIGH);
      result.data_drive_enable = !read_part_in;
      if (!read_part_in && (phase_in == PH_LOW || phase_in == PH_HIGH)) begin
         result.data_out = shift_in[bit_in[SHIFT_IDX_W-1:0]];
      end
      result.chip_enable = active_in;
      result.busy_res    = active_in;
      result.read_valid  = read_done;
      if (read_done) begin
         result.read_value = bcd_to_bin(cmd_ff, rx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         active_ff  <= 1'b0;
         reading_ff <= 1'b0;
         cmd_ff     <= 8'd0;
         shift_ff   <= '0;
         rx_ff      <= 8'd0;
         bit_ff     <= '0;
         tick_ff    <= 8'd0;
      end else if (step) begin
         phase_ff   <= phase_in;
         active_ff  <= active_in;
         reading_ff <= reading_in;
         cmd_ff     <= cmd_in;
         shift_ff   <= shift_in;
         rx_ff      <= rx_in;
         bit_ff     <= bit_in;
         tick_ff    <= tick_in;
      end
   end

   `TWRTC_ASSERT(a_idle_iff_inactive, clock, reset, (phase_ff == PH_IDLE) == !active_ff)
   `TWRTC_ASSERT(a_reading_needs_active, clock, reset, reading_ff |-> active_ff)
   `TWRTC_ASSERT(a_bit_in_range, clock, reset, bit_ff < BIT_IDX_W'(TRANSFER_BITS))
   `TWRTC_ASSERT(a_done_goes_idle, clock, reset, (step && read_done) |=> (phase_ff == PH_IDLE))

endmodule

`default_nettype wire

// ===== src/twrtc_out_stage.sv =====
// ----------------------------------------------------------------------------
// twrtc_out_stage
// result register feeding the rsp stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twrtc_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire twrtc_pkg::result_type result,
   output logic                      slot_free,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [15:0]               rsp_tdata
);
   import twrtc_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff;

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, res_ff.read_value, res_ff.read_valid, res_ff.busy_res,
                        res_ff.chip_enable, res_ff.data_drive_enable, res_ff.data_out,
                        res_ff.serial_clock};

endmodule

`default_nettype wire

// ===== src/three_wire_rtc_serial_master.sv =====
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master
// host-side master for a three-wire rtc link, one tick word in, one pin word out
// ----------------------------------------------------------------------------
//  channel   | dir | handshake                | payload
//  req_      | in  | req_tvalid / req_tready  | tick word: start, address, data, io pin
//  rsp_      | out | rsp_tvalid / rsp_tready  | pin levels, busy, read result
//  csr_      | in  | csr_valid / csr_ready    | timing register index and value
//
//  one tick word is taken every cycle while the result side keeps up; the
//  input register loads it at the accepting edge, then the result register
//  takes its pin word as the engine steps; it waits on rsp_ until taken
//  the phase counter and shifter close their loop inside the engine
//  reset clears the pipeline and the sequencer and loads the default timings
//  with rsp_tready low the result register holds, the input register takes one
//  more word and then req_tready falls
//  csr writes are always taken (csr_ready tied high)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module three_wire_rtc_serial_master (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: start_req[0], reg_address[8:1], write_data[16:9], io_sample[17], zero[23:18]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,
   // req_tuser: operation[0]
   input  wire logic        req_tuser,
   // rsp_tdata: serial_clock[0], data_out[1], data_drive_enable[2], chip_enable[3],
   //            busy_res[4], read_valid[5], read_value[13:6], zero[15:14]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   // timing register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_data
);
   import twrtc_pkg::*;

   item_type   req_item, item;
   logic       item_valid;
   logic       slot_free;
   logic       advance;
   result_type result;
   csr_wr_type csr_wr;

   // unpack the incoming word
   assign req_item.start_req   = req_tdata[0];
   assign req_item.operation   = req_tuser;
   assign req_item.reg_address = req_tdata[8:1];
   assign req_item.write_data  = req_tdata[16:9];
   assign req_item.io_sample   = req_tdata[17];

   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid && csr_ready;
   assign csr_wr.index = csr_index_type'(csr_index);
   assign csr_wr.data  = csr_data;

   // step the sequencer whenever a tick is held and the result slot can take it
   assign advance = item_valid && slot_free;

   twrtc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   twrtc_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .csr_wr (csr_wr),
      .step   (advance),
      .item   (item),
      .result (result)
   );

   twrtc_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench for three_wire_rtc_serial_master
// drives tick words into the serial master, predicts every pin word it returns
// and compares them field by field; covers register writes and reads, odd and
// unknown commands, timing extremes and timing changes in mid transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import twrtc_pkg::*;

   localparam int LONG_RUN = 1_000_000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // req_tdata: start_req[0], reg_address[8:1], write_data[16:9], io_sample[17]
   logic [23:0] req_tdata;
   // req_tuser: operation[0]
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // rsp_tdata: serial_clock[0], data_out[1], data_drive_enable[2], chip_enable[3],
   //            busy_res[4], read_valid[5], read_value[13:6]
   logic [15:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [7:0]  csr_data;

   three_wire_rtc_serial_master dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted link engine: timing registers and sequencer state
   logic [7:0]  cfg_half;
   logic [7:0]  cfg_setup;
   logic        eng_active;
   logic        eng_reading;
   logic [7:0]  eng_cmd;
   logic [15:0] eng_shift;
   logic [7:0]  eng_rx;
   logic [4:0]  eng_bit;
   phase_type   eng_phase;
   logic [7:0]  eng_count;

   // pin words still owed by the block, oldest first
   result_type  pins_expected[$];

   int idle_max;
   int failures;
   int tick_words;
   int link_writes;
   int link_reads;
   int timing_writes;
   int words_checked;

   // valid bits of each time register; anything else passes unmasked
   function automatic logic [7:0] field_mask(input logic [7:0] cmd);
      case (cmd)
         CMD_SECONDS, CMD_MINUTES: return 8'h7F;
         CMD_HOURS, CMD_MONTH:     return 8'h1F;
         CMD_DATE:                 return 8'h3F;
         CMD_DAY:                  return 8'h07;
         default:                  return 8'hFF;
      endcase
   endfunction

   function automatic logic [7:0] rtc_command(input int slot);
      case (slot)
         0:       return CMD_SECONDS;
         1:       return CMD_MINUTES;
         2:       return CMD_HOURS;
         3:       return CMD_DATE;
         4:       return CMD_MONTH;
         5:       return CMD_DAY;
         default: return CMD_YEAR;
      endcase
   endfunction

   // one tick of the link engine: update the state, return the pin word
   function automatic result_type advance_engine(input item_type t);
      result_type r;
      logic [7:0] masked;
      logic       drive;
      r = '0;
      case (eng_phase)
         PH_IDLE: begin
            if (t.start_req) begin
               eng_active  = 1'b1;
               eng_reading = t.operation;
               eng_cmd     = t.reg_address;
               // a read sends command + 1, wrapping at 8 bits
               if (t.operation) begin
                  eng_shift = {8'h00, 8'(t.reg_address + 8'd1)};
                  link_reads++;
               end else begin
                  eng_shift = {t.write_data, t.reg_address};
                  link_writes++;
               end
               eng_rx    = 8'h00;
               eng_bit   = '0;
               eng_phase = PH_SETUP;
               eng_count = 8'd1;
            end
         end
         PH_SETUP: begin
            if (eng_count >= cfg_setup) begin
               eng_phase = PH_LOW;
               eng_count = 8'd1;
            end else begin
               eng_count++;
            end
         end
         PH_LOW: begin
            if (eng_count >= cfg_half) begin
               // read bits are sampled at the end of the low half
               if (eng_reading && eng_bit >= 5'd8)
                  eng_rx = eng_rx | (8'(t.io_sample) << eng_bit[2:0]);
               eng_phase = PH_HIGH;
               eng_count = 8'd1;
            end else begin
               eng_count++;
            end
         end
         default: begin
            if (eng_count >= cfg_half) begin
               eng_bit++;
               eng_count = 8'd1;
               if (eng_bit >= TRANSFER_BITS) begin
                  if (eng_reading) begin
                     masked       = eng_rx & field_mask(eng_cmd);
                     r.read_valid = 1'b1;
                     r.read_value = masked - 8'd6 * {4'h0, masked[7:4]};
                  end
                  eng_active  = 1'b0;
                  eng_reading = 1'b0;
                  eng_bit     = '0;
                  eng_phase   = PH_IDLE;
                  eng_count   = 8'd0;
               end else begin
                  eng_phase = PH_LOW;
               end
            end else begin
               eng_count++;
            end
         end
      endcase
      drive = !(eng_reading && eng_bit >= 5'd8);
      r.serial_clock      = (eng_phase == PH_HIGH);
      r.data_drive_enable = drive;
      r.chip_enable       = eng_active;
      r.busy_res          = eng_active;
      if (drive && (eng_phase == PH_LOW || eng_phase == PH_HIGH))
         r.data_out = eng_shift[eng_bit[3:0]];
      return r;
   endfunction

   function automatic int pick_gap();
      return (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
   endfunction

   // mostly real rtc commands, sometimes any byte
   function automatic item_type random_tick();
      item_type t;
      t.start_req = ($urandom_range(0, 9) < 6);
      t.operation = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) != 0)
         t.reg_address = rtc_command($urandom_range(0, 6));
      else
         t.reg_address = 8'($urandom_range(0, 255));
      t.write_data = 8'($urandom_range(0, 255));
      t.io_sample  = 1'($urandom_range(0, 1));
      return t;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   // send one tick word; valid stays high on return so words can run back to back
   task automatic send_tick(input item_type t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b000000, t.io_sample, t.write_data, t.reg_address, t.start_req};
      req_tuser  <= t.operation;
      do @(posedge clock); while (!req_tready);
      pins_expected.push_back(advance_engine(t));
      tick_words++;
      @(negedge clock);
   endtask

   // start a transfer, then tick on with random content (starts included,
   // which the busy engine ignores) until idle or the tick budget is spent
   task automatic run_transfer(input logic op, input logic [7:0] addr,
                               input logic [7:0] wdata, input int budget);
      item_type t;
      t             = random_tick();
      t.start_req   = 1'b1;
      t.operation   = op;
      t.reg_address = addr;
      t.write_data  = wdata;
      send_tick(t);
      tick_on(budget);
   endtask

   task automatic tick_on(input int budget);
      int n;
      n = 0;
      while (eng_phase != PH_IDLE && n < budget) begin
         send_tick(random_tick());
         n++;
      end
   endtask

   // timing writes only with the pipeline drained
   task automatic write_timing(input csr_index_type idx, input logic [7:0] value);
      req_tvalid <= 1'b0;
      wait (pins_expected.size() == 0);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_HALF_PERIOD)
         cfg_half = value;
      else
         cfg_setup = value;
      timing_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // idle pins: clock and chip enable low, data driven low
   task automatic test_idle_pins();
      item_type t;
      repeat (6) begin
         t           = random_tick();
         t.start_req = 1'b0;
         send_tick(t);
      end
   endtask

   // a write of zero data at the reset timing, sped up part way through; then
   // writes at the fastest timing with all-ones data and an odd command
   task automatic test_register_writes();
      run_transfer(1'b0, CMD_SECONDS, 8'h00, 40);
      write_timing(CSR_HALF_PERIOD, 8'd1);
      tick_on(LONG_RUN);
      run_transfer(1'b0, CMD_YEAR, 8'hFF, LONG_RUN);
      run_transfer(1'b0, 8'h85, 8'hA5, LONG_RUN);
   endtask

   // every time register, then one that is unknown, odd and wraps;
   // each start follows the previous completion on the next tick
   task automatic test_register_reads();
      for (int i = 0; i < 7; i++)
         run_transfer(1'b1, rtc_command(i), 8'($urandom_range(0, 255)), LONG_RUN);
      run_transfer(1'b1, 8'hFF, 8'h00, LONG_RUN);
   endtask

   task automatic test_timing_extremes();
      // zero timing behaves as one
      write_timing(CSR_HALF_PERIOD, 8'd0);
      write_timing(CSR_SETUP, 8'd0);
      run_transfer(1'b1, CMD_HOURS, 8'h00, LONG_RUN);
      // slowest link, cut short in the setup interval and in a low half
      write_timing(CSR_HALF_PERIOD, 8'd255);
      write_timing(CSR_SETUP, 8'd255);
      run_transfer(1'b1, CMD_MINUTES, 8'h00, 10);
      write_timing(CSR_SETUP, 8'd5);
      tick_on(10);
      write_timing(CSR_HALF_PERIOD, 8'd1);
      tick_on(LONG_RUN);
   endtask

   // random tick words under a few short timings; one phase runs without idling
   task automatic test_random_traffic();
      logic [7:0] half;
      logic [7:0] setup;
      for (int p = 0; p < 5; p++) begin
         case (p)
            0:       begin half = 8'd1; setup = 8'd1; end
            1:       begin half = 8'd2; setup = 8'd1; end
            2:       begin half = 8'd1; setup = 8'd3; end
            3:       begin half = 8'd3; setup = 8'd2; end
            default: begin half = 8'd1; setup = 8'd1; end
         endcase
         // written while a transfer may still be under way
         write_timing(CSR_HALF_PERIOD, half);
         write_timing(CSR_SETUP, setup);
         idle_max = (p == 2) ? 0 : 4;
         repeat (20) send_tick(random_tick());
      end
      idle_max = 4;
   endtask

   // result side: a fresh stall before each pin word
   initial begin : rsp_pacing
      int stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // compare each accepted pin word with the oldest prediction
   always @(posedge clock) begin : pin_check
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pins_expected.size() == 0) begin
            $error("pin word %h arrived with nothing expected", rsp_tdata);
            failures++;
         end else begin
            want = pins_expected.pop_front();
            check_field("serial_clock", 8'(want.serial_clock), 8'(rsp_tdata[0]));
            check_field("data_out", 8'(want.data_out), 8'(rsp_tdata[1]));
            check_field("data_drive_enable", 8'(want.data_drive_enable),
                        8'(rsp_tdata[2]));
            check_field("chip_enable", 8'(want.chip_enable), 8'(rsp_tdata[3]));
            check_field("busy_res", 8'(want.busy_res), 8'(rsp_tdata[4]));
            check_field("read_valid", 8'(want.read_valid), 8'(rsp_tdata[5]));
            check_field("read_value", want.read_value, rsp_tdata[13:6]);
            words_checked++;
         end
      end
   end

   // main sequence
   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = 1'b0;
      csr_data      = 8'h00;
      idle_max      = 4;
      failures      = 0;
      tick_words    = 0;
      link_writes   = 0;
      link_reads    = 0;
      timing_writes = 0;
      words_checked = 0;
      // predictor starts from the reset state and default timings
      cfg_half      = HALF_PERIOD_RESET;
      cfg_setup     = SETUP_RESET;
      eng_active    = 1'b0;
      eng_reading   = 1'b0;
      eng_cmd       = 8'h00;
      eng_shift     = 16'h0000;
      eng_rx        = 8'h00;
      eng_bit       = '0;
      eng_phase     = PH_IDLE;
      eng_count     = 8'd0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_idle_pins();
      test_register_writes();
      test_register_reads();
      test_timing_extremes();
      test_random_traffic();

      // drain, then watch for anything stray
      req_tvalid <= 1'b0;
      wait (pins_expected.size() == 0);
      repeat (10) @(posedge clock);
      $display("checked %0d pin words from %0d tick words", words_checked, tick_words);
      $display("link saw %0d writes and %0d reads over %0d timing register writes",
               link_writes, link_reads, timing_writes);
      if (failures == 0)
         $display("PASS three_wire_rtc_serial_master");
      else
         $display("FAIL three_wire_rtc_serial_master");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("FAIL three_wire_rtc_serial_master");
      $finish;
   end

endmodule
